// ===== rtl/core/segment_box_slab_intersect_core_defines.svh =====
// Assertion macros used by the top-level core file.
`ifndef SEGMENT_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sbsi_pkg.sv =====
package sbsi_pkg;

  localparam int CW          = 32;
  localparam int TW          = 17;
  localparam int QBITS       = 16;
  localparam int NAXES       = 3;
  localparam int PW          = CW + 1 + TW + 1;
  localparam int PIPE_STAGES = QBITS + 3;

  localparam logic [TW-1:0] T_ONE = TW'(1) << QBITS;

  localparam logic [1:0] RK_ZERO = 2'd0;
  localparam logic [1:0] RK_ONE  = 2'd1;
  localparam logic [1:0] RK_DIV  = 2'd2;

  typedef struct packed {
    logic                 reject;
    logic [TW-1:0]        t0;
    logic [TW-1:0]        t1;
    logic signed [CW-1:0] s;
    logic signed [CW:0]   d;
  } lane_res_t;

  function automatic logic [TW-1:0] rk_to_t(input logic [1:0] kind,
                                            input logic [QBITS-1:0] q);
    logic [TW-1:0] t;
    unique case (kind)
      RK_ONE:  t = T_ONE;
      RK_DIV:  t = {1'b0, q};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/sbsi_div.sv =====
module sbsi_div import sbsi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [CW-1:0]    num,
  input  logic [CW-1:0]    den,
  input  logic [1:0]       kind,
  output logic [QBITS-1:0] quo,
  output logic [1:0]       kind_out
);

  logic [CW-1:0]    rem_r  [QBITS];
  logic [CW-1:0]    den_r  [QBITS];
  logic [QBITS-1:0] q_r    [QBITS];
  logic [1:0]       kind_r [QBITS];

  // One quotient bit per stage; remainder stays below den whenever num starts below it.
  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [CW-1:0]    rem_in;
    logic [CW-1:0]    den_in;
    logic [QBITS-1:0] q_in;
    logic [1:0]       k_in;
    logic [CW:0]      shl;
    logic [CW:0]      diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign k_in   = kind;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign k_in   = kind_r[k-1];
    end

    assign shl  = {rem_in, 1'b0};
    assign diff = shl - {1'b0, den_in};
    assign ge   = shl >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[CW-1:0] : shl[CW-1:0];
        den_r[k]  <= den_in;
        q_r[k]    <= {q_in[QBITS-2:0], ge};
        kind_r[k] <= k_in;
      end
    end
  end

  assign quo      = q_r[QBITS-1];
  assign kind_out = kind_r[QBITS-1];

endmodule

// ===== rtl/core/sbsi_lane.sv =====
module sbsi_lane import sbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  logic signed [CW-1:0] lo,
  input  logic signed [CW-1:0] hi,
  output lane_res_t            res
);

  logic signed [CW+1:0] ax, bx, lox, hix;
  logic signed [CW+1:0] den_w, num0_w, num1_w;
  logic                 up, rej_w, need0, need1;
  logic [1:0]           k0_w, k1_w;

  logic [CW-1:0]        num0_r, num1_r, den_r;
  logic [1:0]           k0_r, k1_r;
  logic                 rej_r;
  logic signed [CW-1:0] s_r;
  logic signed [CW:0]   d_r;

  logic                 rej_dly_r [QBITS];
  logic signed [CW-1:0] s_dly_r   [QBITS];
  logic signed [CW:0]   d_dly_r   [QBITS];

  logic [QBITS-1:0] q0, q1;
  logic [1:0]       k0_o, k1_o;

  always_comb begin
    ax     = {{2{a[CW-1]}}, a};
    bx     = {{2{b[CW-1]}}, b};
    lox    = {{2{lo[CW-1]}}, lo};
    hix    = {{2{hi[CW-1]}}, hi};
    up     = a < b;
    den_w  = up ? (bx - ax) : (ax - bx);
    rej_w  = up ? ((a > hi) || (b < lo)) : ((b > hi) || (a < lo));
    need0  = up ? (a < lo) : (a > hi);
    need1  = up ? (b > hi) : (b < lo);
    num0_w = up ? (lox - ax) : (ax - hix);
    num1_w = up ? (hix - ax) : (ax - lox);
    if (!need0 || num0_w <= 0) begin
      k0_w = RK_ZERO;
    end else if (num0_w >= den_w) begin
      k0_w = RK_ONE;
    end else begin
      k0_w = RK_DIV;
    end
    if (!need1) begin
      k1_w = RK_ONE;
    end else if (num1_w <= 0) begin
      k1_w = RK_ZERO;
    end else if (num1_w >= den_w) begin
      k1_w = RK_ONE;
    end else begin
      k1_w = RK_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= num0_w[CW-1:0];
      num1_r <= num1_w[CW-1:0];
      den_r  <= den_w[CW-1:0];
      k0_r   <= k0_w;
      k1_r   <= k1_w;
      rej_r  <= rej_w;
      s_r    <= a;
      d_r    <= bx[CW:0] - ax[CW:0];
    end
  end

  sbsi_div u_div_enter (
    .clk      (clk),
    .en       (en),
    .num      (num0_r),
    .den      (den_r),
    .kind     (k0_r),
    .quo      (q0),
    .kind_out (k0_o)
  );

  sbsi_div u_div_exit (
    .clk      (clk),
    .en       (en),
    .num      (num1_r),
    .den      (den_r),
    .kind     (k1_r),
    .quo      (q1),
    .kind_out (k1_o)
  );

  // Keep the start point, delta and reject flag in step with the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      rej_dly_r[0] <= rej_r;
      s_dly_r[0]   <= s_r;
      d_dly_r[0]   <= d_r;
      for (int k = 1; k < QBITS; k++) begin
        rej_dly_r[k] <= rej_dly_r[k-1];
        s_dly_r[k]   <= s_dly_r[k-1];
        d_dly_r[k]   <= d_dly_r[k-1];
      end
    end
  end

  always_comb begin
    res.reject = rej_dly_r[QBITS-1];
    res.t0     = rk_to_t(k0_o, q0);
    res.t1     = rk_to_t(k1_o, q1);
    res.s      = s_dly_r[QBITS-1];
    res.d      = d_dly_r[QBITS-1];
  end

endmodule

// ===== rtl/core/sbsi_merge.sv =====
module sbsi_merge import sbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  lane_res_t            res [NAXES],
  output logic                 hit,
  output logic [TW-1:0]        entry_t,
  output logic signed [CW-1:0] entry [NAXES]
);

  logic [TW-1:0]        enter_w, leave_w;
  logic                 rej_w;

  logic                 hit_m_r;
  logic [TW-1:0]        t_m_r;
  logic signed [CW-1:0] s_m_r [NAXES];
  logic signed [CW:0]   d_m_r [NAXES];

  logic                 hit_p_r;
  logic [TW-1:0]        t_p_r;
  logic signed [CW-1:0] s_p_r [NAXES];
  logic signed [PW-1:0] p_p_r [NAXES];

  always_comb begin
    enter_w = '0;
    leave_w = T_ONE;
    rej_w   = 1'b0;
    for (int i = 0; i < NAXES; i++) begin
      if (res[i].t0 > enter_w) enter_w = res[i].t0;
      if (res[i].t1 < leave_w) leave_w = res[i].t1;
      rej_w = rej_w | res[i].reject;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_m_r <= !rej_w && (leave_w >= enter_w);
      t_m_r   <= (!rej_w && (leave_w >= enter_w)) ? enter_w : '0;
      for (int i = 0; i < NAXES; i++) begin
        s_m_r[i] <= res[i].s;
        d_m_r[i] <= res[i].d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_p_r <= hit_m_r;
      t_p_r   <= t_m_r;
      for (int i = 0; i < NAXES; i++) begin
        s_p_r[i] <= s_m_r[i];
        p_p_r[i] <= PW'(d_m_r[i] * $signed({1'b0, t_m_r}));
      end
    end
  end

  // Arithmetic shift floors negative products; then add and clamp, or give zero on a miss.
  for (genvar i = 0; i < NAXES; i++) begin : g_pt
    logic signed [PW-QBITS-1:0] q;
    logic signed [PW-QBITS:0]   sum;
    always_comb begin
      q   = p_p_r[i][PW-1:QBITS];
      sum = {{(PW-QBITS+1-CW){s_p_r[i][CW-1]}}, s_p_r[i]} + {q[PW-QBITS-1], q};
      if (!hit_p_r) begin
        entry[i] = '0;
      end else if (sum > $signed({{(PW-QBITS+2-CW){1'b0}}, {(CW-1){1'b1}}})) begin
        entry[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (sum < $signed({{(PW-QBITS+2-CW){1'b1}}, {(CW-1){1'b0}}})) begin
        entry[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        entry[i] = sum[CW-1:0];
      end
    end
  end

  assign hit     = hit_p_r;
  assign entry_t = t_p_r;

endmodule

// ===== rtl/core/segment_box_slab_intersect_core.sv =====
// Segment versus axis-aligned box test by the slab method, Q16.16 fixed point.
// Input channel (in_valid / in_stall): segment start, end and box corners.
// Result channel (out_valid / out_stall): hit flag, entry parameter in Q1.16
// (65536 is 1.0) and the entry point, all zero on a miss.
// An item is taken on a clock edge with valid high and stall low.
// Each axis runs in its own lane with two 16-stage pipelined dividers for
// the entry and exit ratios; a merge stage takes max/min over the lanes,
// then a multiply stage and the output register form the entry point.
// One item is accepted every cycle while the result side keeps up.
// When the result register is full and out_stall is high, the whole pipeline
// holds and in_stall rises in the same cycle.
// rst_n is synchronous, active low, and clears all stage valid flags and
// out_valid; items in flight are dropped.
module segment_box_slab_intersect_core import sbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_start_x,
  input  logic signed [CW-1:0] in_start_y,
  input  logic signed [CW-1:0] in_start_z,
  input  logic signed [CW-1:0] in_end_x,
  input  logic signed [CW-1:0] in_end_y,
  input  logic signed [CW-1:0] in_end_z,
  input  logic signed [CW-1:0] in_box_lo_x,
  input  logic signed [CW-1:0] in_box_lo_y,
  input  logic signed [CW-1:0] in_box_lo_z,
  input  logic signed [CW-1:0] in_box_hi_x,
  input  logic signed [CW-1:0] in_box_hi_y,
  input  logic signed [CW-1:0] in_box_hi_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [TW-1:0]        out_entry_t,
  output logic signed [CW-1:0] out_entry_x,
  output logic signed [CW-1:0] out_entry_y,
  output logic signed [CW-1:0] out_entry_z
);

`include "segment_box_slab_intersect_core_defines.svh"

  logic en;
  logic [PIPE_STAGES-1:0] vld_r;
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [TW-1:0]          out_t_r;
  logic signed [CW-1:0]   out_pt_r [NAXES];

  logic signed [CW-1:0] a_w  [NAXES];
  logic signed [CW-1:0] b_w  [NAXES];
  logic signed [CW-1:0] lo_w [NAXES];
  logic signed [CW-1:0] hi_w [NAXES];
  lane_res_t            res  [NAXES];
  logic                 hit_w;
  logic [TW-1:0]        t_w;
  logic signed [CW-1:0] pt_w [NAXES];

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign a_w  = '{in_start_x, in_start_y, in_start_z};
  assign b_w  = '{in_end_x, in_end_y, in_end_z};
  assign lo_w = '{in_box_lo_x, in_box_lo_y, in_box_lo_z};
  assign hi_w = '{in_box_hi_x, in_box_hi_y, in_box_hi_z};

  for (genvar i = 0; i < NAXES; i++) begin : g_lane
    sbsi_lane u_lane (
      .clk (clk),
      .en  (en),
      .a   (a_w[i]),
      .b   (b_w[i]),
      .lo  (lo_w[i]),
      .hi  (hi_w[i]),
      .res (res[i])
    );
  end

  sbsi_merge u_merge (
    .clk     (clk),
    .en      (en),
    .res     (res),
    .hit     (hit_w),
    .entry_t (t_w),
    .entry   (pt_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_STAGES-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= hit_w;
      out_t_r   <= t_w;
      out_pt_r  <= pt_w;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_entry_t = out_t_r;
  assign out_entry_x = out_pt_r[0];
  assign out_entry_y = out_pt_r[1];
  assign out_entry_z = out_pt_r[2];

  `SBSI_ASSERT_NOW(a_miss_zero, out_valid && !out_hit,
    out_entry_t == '0 && out_entry_x == '0 && out_entry_y == '0 && out_entry_z == '0,
    "miss result carries nonzero fields")
  `SBSI_ASSERT_NOW(a_t_range, out_valid && out_hit, out_entry_t <= T_ONE,
    "entry parameter above one")
  `SBSI_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
    "input held without a blocked result")
  `SBSI_ASSERT_NEXT(a_drain, vld_r[PIPE_STAGES-1] && !in_stall, out_valid,
    "last stage item did not reach the output")

endmodule

// ===== bench/tb_segment_box_slab_intersect_core.sv =====
module tb_segment_box_slab_intersect_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbsi_pkg::*;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t s[3];
    coord_t e[3];
    coord_t lo[3];
    coord_t hi[3];
  } seg_box_t;

  typedef struct {
    logic          hit;
    logic [TW-1:0] t;
    coord_t        p[3];
  } entry_res_t;

  // floor(num * 2^16 / den) clipped to [0, 1.0]
  function automatic longint crossing_ratio(longint num, longint den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return 64'd65536;
    return (num <<< 16) / den;
  endfunction

  function automatic coord_t entry_coord(longint s, longint e, longint t);
    longint p, q, r;
    p = (e - s) * t;
    if (p >= 0) q = p >>> 16;
    else q = -((-p + 64'hFFFF) >>> 16);
    r = s + q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return coord_t'(r);
  endfunction

  function automatic entry_res_t slab_entry(seg_box_t it);
    entry_res_t res;
    longint enter, leave, a, b, l, h, t0, t1;
    bit hit;
    enter = 0;
    leave = 65536;
    hit = 1;
    for (int i = 0; i < 3 && hit; i++) begin
      a = it.s[i]; b = it.e[i]; l = it.lo[i]; h = it.hi[i];
      if (a < b) begin
        if (a > h || b < l) begin
          hit = 0;
          break;
        end
        t0 = (a < l) ? crossing_ratio(l - a, b - a) : 0;
        t1 = (b > h) ? crossing_ratio(h - a, b - a) : 65536;
      end else begin
        if (b > h || a < l) begin
          hit = 0;
          break;
        end
        t0 = (a > h) ? crossing_ratio(a - h, a - b) : 0;
        t1 = (b < l) ? crossing_ratio(a - l, a - b) : 65536;
      end
      if (t0 > enter) enter = t0;
      if (t1 < leave) leave = t1;
      if (leave < enter) hit = 0;
    end
    res.hit = hit;
    res.t = hit ? enter[TW-1:0] : '0;
    for (int i = 0; i < 3; i++)
      res.p[i] = hit ? entry_coord(it.s[i], it.e[i], enter) : '0;
    return res;
  endfunction

  class entry_scoreboard;
    entry_res_t pending[$];
    int errors;

    function void note_item(seg_box_t it);
      pending.push_back(slab_entry(it));
    endfunction

    function void check_result(entry_res_t got);
      entry_res_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit exp %0d got %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.t !== exp.t) begin
        $error("entry_t exp %0d got %0d", exp.t, got.t);
        errors++;
      end
      if (got.p[0] !== exp.p[0]) begin
        $error("entry_x exp %0d got %0d", exp.p[0], got.p[0]);
        errors++;
      end
      if (got.p[1] !== exp.p[1]) begin
        $error("entry_y exp %0d got %0d", exp.p[1], got.p[1]);
        errors++;
      end
      if (got.p[2] !== exp.p[2]) begin
        $error("entry_z exp %0d got %0d", exp.p[2], got.p[2]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  coord_t in_sx = 0, in_sy = 0, in_sz = 0, in_ex = 0, in_ey = 0, in_ez = 0;
  coord_t in_lx = 0, in_ly = 0, in_lz = 0, in_hx = 0, in_hy = 0, in_hz = 0;
  logic out_valid;
  logic out_stall = 1;
  logic out_hit;
  logic [TW-1:0] out_entry_t;
  coord_t out_entry_x, out_entry_y, out_entry_z;

  entry_scoreboard sb = new();
  seg_box_t items[$];
  bit sending_done = 0;
  bit hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  segment_box_slab_intersect_core dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_start_x(in_sx), .in_start_y(in_sy), .in_start_z(in_sz),
    .in_end_x(in_ex), .in_end_y(in_ey), .in_end_z(in_ez),
    .in_box_lo_x(in_lx), .in_box_lo_y(in_ly), .in_box_lo_z(in_lz),
    .in_box_hi_x(in_hx), .in_box_hi_y(in_hy), .in_box_hi_z(in_hz),
    .out_valid, .out_stall, .out_hit, .out_entry_t,
    .out_entry_x, .out_entry_y, .out_entry_z
  );

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return 32'sh7FFFFFFF - coord_t'($urandom_range(0, 3));
      2: return -32'sh80000000 + coord_t'($urandom_range(0, 3));
      default: return coord_t'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic seg_box_t rand_item();
    seg_box_t it;
    coord_t a, b;
    for (int i = 0; i < 3; i++) begin
      it.s[i] = rand_coord();
      it.e[i] = ($urandom_range(0, 9) == 0) ? it.s[i] : rand_coord();
      a = rand_coord();
      b = rand_coord();
      // mostly well-formed boxes, a few inverted
      if ($urandom_range(0, 9) != 0 && a > b) begin
        it.lo[i] = b; it.hi[i] = a;
      end else begin
        it.lo[i] = a; it.hi[i] = b;
      end
    end
    return it;
  endfunction

  function automatic seg_box_t make_item(coord_t s, coord_t e, coord_t lo, coord_t hi);
    seg_box_t it;
    for (int i = 0; i < 3; i++) begin
      it.s[i] = s; it.e[i] = e; it.lo[i] = lo; it.hi[i] = hi;
    end
    return it;
  endfunction

  // called at a falling edge; drop valid only when a gap is drawn
  task automatic send_item(seg_box_t it);
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    {in_sx, in_sy, in_sz} <= {it.s[0], it.s[1], it.s[2]};
    {in_ex, in_ey, in_ez} <= {it.e[0], it.e[1], it.e[2]};
    {in_lx, in_ly, in_lz} <= {it.lo[0], it.lo[1], it.lo[2]};
    {in_hx, in_hy, in_hz} <= {it.hi[0], it.hi[1], it.hi[2]};
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_item(it);
    @(negedge clk);
  endtask

  initial begin
    seg_box_t it;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: extremes, degenerate axes, inverted boxes, edge crossings
    items.push_back(make_item(-32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF));
    items.push_back(make_item(32'sh7FFFFFFF, -32'sh80000000, 0, 0));
    items.push_back(make_item(-32'sh80000000, 32'sh7FFFFFFF, 1, 1));
    items.push_back(make_item(0, 0, 0, 0));
    items.push_back(make_item(5, 5, 0, 4));
    items.push_back(make_item(-32'sh10000, 32'sh10000, 0, 32'sh20000));
    items.push_back(make_item(32'sh30000, -32'sh10000, 0, 32'sh20000));
    items.push_back(make_item(0, 32'sh10000, 32'sh20000, 32'sh30000));
    items.push_back(make_item(0, 32'sh10000, 32'sh10000, 32'sh30000));
    items.push_back(make_item(0, 32'sh30000, 32'sh20000, 32'sh10000));
    items.push_back(make_item(-7, 3, -3, -3));
    items.push_back(make_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF));
    items.push_back(make_item(-1, 0, -32'sh80000000, -32'sh80000000));
    items.push_back(make_item(-32'sh55555555, 32'sh2AAAAAAA, 32'sh12345678, -32'sh12345678));
    it = make_item(0, 32'sh10000, 0, 32'sh10000);
    it.s[1] = 32'sh50000; it.e[1] = 32'sh50000;
    items.push_back(it);
    it = make_item(-32'sh80000000, 32'sh7FFFFFFF, -32'sh100, 32'sh100);
    it.s[2] = 32'sh7FFFFFFF; it.e[2] = -32'sh80000000;
    items.push_back(it);
    for (int n = 0; n < 1500; n++) items.push_back(rand_item());
    foreach (items[k]) send_item(items[k]);
    in_valid <= 0;
    sending_done = 1;
  end

  // one long receiver hold-off partway in, so the pipeline holds and backs up
  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (120) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    int wait_cycles;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
      end else if (wait_cycles > 0) begin
        out_stall <= 1;
        wait_cycles--;
      end else begin
        out_stall <= 0;
        wait_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end
    end
  end

  always @(posedge clk) begin
    entry_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.hit = out_hit;
      got.t = out_entry_t;
      got.p[0] = out_entry_x;
      got.p[1] = out_entry_y;
      got.p[2] = out_entry_z;
      sb.check_result(got);
    end
  end

  initial begin
    wait (sending_done);
    wait (sb.pending.size() == 0);
    repeat (PIPE_STAGES + 10) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_segment_box_slab_intersect_core passed");
    else
      $display("tb_segment_box_slab_intersect_core failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_segment_box_slab_intersect_core failed");
    $finish;
  end
endmodule
